@@ design/lcdseq_pkg.sv @@
package lcdseq_pkg;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_CMD,
    ACT_CHAR,
    ACT_INIT
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STARTUP,
    PH_POLL_HIGH,
    PH_POLL_LOW,
    PH_SETUP,
    PH_STROBE
  } phase_t;

  typedef enum logic {
    CFG_PULSE_TICKS,
    CFG_STARTUP_TICKS
  } cfg_index_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] byte_value;
    logic       busy_pin;
  } item_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable_line;
    logic [7:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
    logic       accepted;
  } result_t;

  localparam logic [7:0]  PULSE_TICKS_RESET   = 8'd10;
  localparam logic [15:0] STARTUP_TICKS_RESET = 16'd25000;
  localparam int          CFG_DATA_W          = 16;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0D;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] cmd;
    case (idx)
      2'd0:    cmd = CMD_FUNCTION_SET;
      2'd1:    cmd = CMD_DISPLAY_ON;
      2'd2:    cmd = CMD_CLEAR;
      default: cmd = CMD_ENTRY_MODE;
    endcase
    return cmd;
  endfunction

endpackage

@@ design/lcdseq_front.sv @@
module lcdseq_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action,
  input  logic [7:0]          byte_value,
  input  logic                busy_pin,
  output logic                item_valid,
  output lcdseq_pkg::item_t   item,
  input  logic                item_take
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcdseq_pkg::item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_take;
  lcdseq_pkg::item_t incoming;

  // classify the raw fields into a queued item
  always_comb begin
    incoming.action     = lcdseq_pkg::action_t'(action);
    incoming.byte_value = byte_value;
    incoming.busy_pin   = busy_pin;
  end

  assign full       = (count == CW'(DEPTH));
  assign item_valid = (count != '0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_take) begin
        count <= count + CW'(1);
      end else if (!do_push && do_take) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/lcdseq_back.sv @@
module lcdseq_back #(
  parameter int OUT_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          pulse_ticks,
  input  logic [15:0]         startup_ticks,
  input  logic                item_valid,
  input  lcdseq_pkg::item_t   item,
  output logic                item_take,
  output logic                empty,
  input  logic                pop,
  output lcdseq_pkg::result_t result
);

  localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  lcdseq_pkg::phase_t phase;
  lcdseq_pkg::phase_t phase_next;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [7:0]  held_byte;
  logic [7:0]  held_byte_next;
  logic        held_select;
  logic        held_select_next;
  logic [2:0]  init_index;
  logic [2:0]  init_index_next;
  logic        busy_seen;
  logic        busy_seen_next;
  logic        acc;

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic        done;

  lcdseq_pkg::result_t res_new;
  lcdseq_pkg::result_t out_slots [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] out_count;
  logic          do_pop;

  assign item_take = item_valid && (out_count != CW'(OUT_DEPTH));
  assign empty     = (out_count == '0);
  assign result    = out_slots[rd_ptr];
  assign do_pop    = pop && !empty;

  assign tick_inc = tick_count + 16'd1;
  assign limit    = (phase == lcdseq_pkg::PH_STARTUP) ? startup_ticks : {8'd0, pulse_ticks};
  assign done     = (tick_inc >= limit);

  // next state
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    held_byte_next   = held_byte;
    held_select_next = held_select;
    init_index_next  = init_index;
    busy_seen_next   = busy_seen;
    acc              = 1'b0;
    if (item.action == lcdseq_pkg::ACT_TICK) begin
      unique case (phase)
        lcdseq_pkg::PH_STARTUP: begin
          tick_count_next = done ? 16'd0 : tick_inc;
          if (done) begin
            init_index_next  = 3'd1;
            held_byte_next   = lcdseq_pkg::init_cmd(2'd0);
            held_select_next = 1'b0;
            busy_seen_next   = 1'b1;
            phase_next       = lcdseq_pkg::PH_POLL_HIGH;
          end
        end
        lcdseq_pkg::PH_POLL_HIGH: begin
          tick_count_next = done ? 16'd0 : tick_inc;
          if (done) begin
            busy_seen_next = item.busy_pin;
            phase_next     = lcdseq_pkg::PH_POLL_LOW;
          end
        end
        lcdseq_pkg::PH_POLL_LOW: begin
          tick_count_next = done ? 16'd0 : tick_inc;
          if (done) begin
            phase_next = busy_seen ? lcdseq_pkg::PH_POLL_HIGH : lcdseq_pkg::PH_SETUP;
          end
        end
        lcdseq_pkg::PH_SETUP: begin
          tick_count_next = done ? 16'd0 : tick_inc;
          if (done) begin
            phase_next = lcdseq_pkg::PH_STROBE;
          end
        end
        lcdseq_pkg::PH_STROBE: begin
          tick_count_next = done ? 16'd0 : tick_inc;
          if (done) begin
            if (init_index >= 3'd1 && init_index <= 3'd3) begin
              held_byte_next   = lcdseq_pkg::init_cmd(init_index[1:0]);
              held_select_next = 1'b0;
              busy_seen_next   = 1'b1;
              init_index_next  = init_index + 3'd1;
              phase_next       = lcdseq_pkg::PH_POLL_HIGH;
            end else begin
              init_index_next = 3'd0;
              phase_next      = lcdseq_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          phase_next = lcdseq_pkg::PH_IDLE;
        end
      endcase
    end else if (phase == lcdseq_pkg::PH_IDLE) begin
      acc             = 1'b1;
      tick_count_next = 16'd0;
      init_index_next = 3'd0;
      if (item.action == lcdseq_pkg::ACT_INIT) begin
        held_byte_next   = 8'd0;
        held_select_next = 1'b0;
        phase_next       = lcdseq_pkg::PH_STARTUP;
      end else begin
        held_byte_next   = item.byte_value;
        held_select_next = (item.action == lcdseq_pkg::ACT_CHAR);
        busy_seen_next   = 1'b1;
        phase_next       = lcdseq_pkg::PH_POLL_HIGH;
      end
    end
  end

  // line levels after this transaction
  always_comb begin
    res_new.accepted  = acc;
    res_new.ready_res = (phase_next == lcdseq_pkg::PH_IDLE);
    unique case (phase_next)
      lcdseq_pkg::PH_STARTUP: begin
        res_new.reg_select  = 1'b0;
        res_new.read_write  = 1'b0;
        res_new.enable_line = 1'b0;
        res_new.bus_out     = 8'd0;
        res_new.bus_drive   = 1'b1;
      end
      lcdseq_pkg::PH_POLL_HIGH: begin
        res_new.reg_select  = 1'b0;
        res_new.read_write  = 1'b1;
        res_new.enable_line = 1'b1;
        res_new.bus_out     = 8'd0;
        res_new.bus_drive   = 1'b0;
      end
      lcdseq_pkg::PH_POLL_LOW: begin
        res_new.reg_select  = 1'b0;
        res_new.read_write  = 1'b1;
        res_new.enable_line = 1'b0;
        res_new.bus_out     = 8'd0;
        res_new.bus_drive   = 1'b0;
      end
      lcdseq_pkg::PH_STROBE: begin
        res_new.reg_select  = held_select_next;
        res_new.read_write  = 1'b0;
        res_new.enable_line = 1'b1;
        res_new.bus_out     = held_byte_next;
        res_new.bus_drive   = 1'b1;
      end
      default: begin
        res_new.reg_select  = held_select_next;
        res_new.read_write  = 1'b0;
        res_new.enable_line = 1'b0;
        res_new.bus_out     = held_byte_next;
        res_new.bus_drive   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lcdseq_pkg::PH_IDLE;
      tick_count  <= '0;
      held_byte   <= '0;
      held_select <= 1'b0;
      init_index  <= '0;
      busy_seen   <= 1'b1;
    end else if (item_take) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      held_byte   <= held_byte_next;
      held_select <= held_select_next;
      init_index  <= init_index_next;
      busy_seen   <= busy_seen_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (item_take) begin
      out_slots[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (item_take) begin
        wr_ptr <= (wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (item_take && !do_pop) begin
        out_count <= out_count + CW'(1);
      end else if (!item_take && do_pop) begin
        out_count <= out_count - CW'(1);
      end
    end
  end

endmodule

@@ design/char_lcd_bus_sequencer_core.sv @@
// channel  | direction | handshake        | payload
// input    | in        | push / full      | action, byte_value, busy_pin
// result   | out       | empty / pop      | reg_select .. accepted
// config   | in        | cfg_write        | cfg_index, cfg_data
//
// one transaction per cycle while the result side keeps popping; an item's result is
// written to the result queue once it has passed the input queue and then the
// sequencer register step, and can be popped from the next edge on
// the sequencer advances on taken items, its intervals measured by the tick counter
// rst is synchronous and clears both queues and the sequencer to idle
// full rises only when the result side stalls and both queues have filled
module char_lcd_bus_sequencer_core #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  byte_value,
  input  logic        busy_pin,
  output logic        empty,
  input  logic        pop,
  output logic        reg_select,
  output logic        read_write,
  output logic        enable_line,
  output logic [7:0]  bus_out,
  output logic        bus_drive,
  output logic        ready_res,
  output logic        accepted,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [lcdseq_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]  pulse_ticks;
  logic [15:0] startup_ticks;
  logic        item_valid;
  logic        item_take;
  lcdseq_pkg::item_t   item;
  lcdseq_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks   <= lcdseq_pkg::PULSE_TICKS_RESET;
      startup_ticks <= lcdseq_pkg::STARTUP_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (lcdseq_pkg::cfg_index_t'(cfg_index))
        lcdseq_pkg::CFG_PULSE_TICKS:   pulse_ticks   <= cfg_data[7:0];
        lcdseq_pkg::CFG_STARTUP_TICKS: startup_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcdseq_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .byte_value(byte_value),
    .busy_pin  (busy_pin),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  lcdseq_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pulse_ticks  (pulse_ticks),
    .startup_ticks(startup_ticks),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

  assign reg_select  = result.reg_select;
  assign read_write  = result.read_write;
  assign enable_line = result.enable_line;
  assign bus_out     = result.bus_out;
  assign bus_drive   = result.bus_drive;
  assign ready_res   = result.ready_res;
  assign accepted    = result.accepted;

  // a taken request always leaves the sequencer busy
  a_accept_not_ready: assert property (@(posedge clk) disable iff (rst)
    (!empty && accepted) |-> !ready_res)
    else $error("accepted request reported ready");

  // status reads release the data lines
  a_read_released: assert property (@(posedge clk) disable iff (rst)
    (!empty && read_write) |-> (!bus_drive && bus_out == 8'd0))
    else $error("data lines driven during busy poll");

  // idle lines never show a strobe
  a_idle_no_strobe: assert property (@(posedge clk) disable iff (rst)
    (!empty && ready_res) |-> (!enable_line && !read_write))
    else $error("strobe or read while idle");

endmodule

@@ tb/sv/char_lcd_bus_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_core_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int RUN_CHUNK = 32;
  localparam logic [3:0][7:0] INIT_SEQ = {lcdseq_pkg::CMD_ENTRY_MODE, lcdseq_pkg::CMD_CLEAR,
                                          lcdseq_pkg::CMD_DISPLAY_ON,
                                          lcdseq_pkg::CMD_FUNCTION_SET};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] action = lcdseq_pkg::ACT_TICK;
  logic [7:0] byte_value = 8'd0;
  logic busy_pin = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic reg_select;
  logic read_write;
  logic enable_line;
  logic [7:0] bus_out;
  logic bus_drive;
  logic ready_res;
  logic accepted;
  logic cfg_write = 1'b0;
  logic cfg_index = lcdseq_pkg::CFG_PULSE_TICKS;
  logic [15:0] cfg_data = 16'd0;

  char_lcd_bus_sequencer_core i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .byte_value(byte_value),
    .busy_pin(busy_pin),
    .empty(empty),
    .pop(pop),
    .reg_select(reg_select),
    .read_write(read_write),
    .enable_line(enable_line),
    .bus_out(bus_out),
    .bus_drive(bus_drive),
    .ready_res(ready_res),
    .accepted(accepted),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  lcdseq_pkg::item_t pending_items[$];
  lcdseq_pkg::result_t expected_lines[$];
  int unsigned errors = 0;
  logic item_taken = 1'b0;
  int unsigned quiet_cycles = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_asked = 0;
  int unsigned hold_off_done = 0;
  int unsigned stall_left = 0;

  // settings as last written, used to size the tick runs
  int unsigned cur_pulse = 32'(lcdseq_pkg::PULSE_TICKS_RESET);
  int unsigned cur_startup = 32'(lcdseq_pkg::STARTUP_TICKS_RESET);

  // predictor state
  lcdseq_pkg::phase_t lcd_phase;
  logic [15:0] tick_cnt;
  logic [7:0] held_byte;
  logic held_rs;
  logic [2:0] init_step;
  logic busy_flag;
  logic [7:0] pulse_len;
  logic [15:0] startup_len;

  function automatic bit interval_over(logic [15:0] lim);
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_write(logic [7:0] val, logic sel);
    held_byte = val;
    held_rs = sel;
    tick_cnt = 16'd0;
    busy_flag = 1'b1;
    lcd_phase = lcdseq_pkg::PH_POLL_HIGH;
  endfunction

  function automatic void advance_tick(logic pin);
    case (lcd_phase)
      lcdseq_pkg::PH_STARTUP: begin
        if (interval_over(startup_len)) begin
          init_step = 3'd1;
          start_write(INIT_SEQ[0], 1'b0);
        end
      end
      lcdseq_pkg::PH_POLL_HIGH: begin
        if (interval_over({8'd0, pulse_len})) begin
          busy_flag = pin;
          lcd_phase = lcdseq_pkg::PH_POLL_LOW;
        end
      end
      lcdseq_pkg::PH_POLL_LOW: begin
        if (interval_over({8'd0, pulse_len}))
          lcd_phase = busy_flag ? lcdseq_pkg::PH_POLL_HIGH : lcdseq_pkg::PH_SETUP;
      end
      lcdseq_pkg::PH_SETUP: begin
        if (interval_over({8'd0, pulse_len})) lcd_phase = lcdseq_pkg::PH_STROBE;
      end
      lcdseq_pkg::PH_STROBE: begin
        if (interval_over({8'd0, pulse_len})) begin
          if (init_step >= 3'd1 && init_step <= 3'd3) begin
            start_write(INIT_SEQ[init_step[1:0]], 1'b0);
            init_step = init_step + 3'd1;
          end else begin
            init_step = 3'd0;
            lcd_phase = lcdseq_pkg::PH_IDLE;
          end
        end
      end
      default: lcd_phase = lcdseq_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic lcdseq_pkg::result_t predict_bus_lines(lcdseq_pkg::item_t it);
    lcdseq_pkg::result_t r;
    r.accepted = 1'b0;
    if (it.action == lcdseq_pkg::ACT_TICK) begin
      advance_tick(it.busy_pin);
    end else if (lcd_phase == lcdseq_pkg::PH_IDLE) begin
      r.accepted = 1'b1;
      if (it.action == lcdseq_pkg::ACT_INIT) begin
        held_byte = 8'd0;
        held_rs = 1'b0;
        tick_cnt = 16'd0;
        init_step = 3'd0;
        lcd_phase = lcdseq_pkg::PH_STARTUP;
      end else begin
        init_step = 3'd0;
        start_write(it.byte_value, it.action == lcdseq_pkg::ACT_CHAR);
      end
    end
    r.reg_select = held_rs;
    r.read_write = 1'b0;
    r.enable_line = 1'b0;
    r.bus_out = held_byte;
    r.bus_drive = 1'b1;
    case (lcd_phase)
      lcdseq_pkg::PH_STARTUP: begin
        r.reg_select = 1'b0;
        r.bus_out = 8'd0;
      end
      lcdseq_pkg::PH_POLL_HIGH, lcdseq_pkg::PH_POLL_LOW: begin
        r.reg_select = 1'b0;
        r.read_write = 1'b1;
        r.enable_line = lcd_phase == lcdseq_pkg::PH_POLL_HIGH;
        r.bus_out = 8'd0;
        r.bus_drive = 1'b0;
      end
      lcdseq_pkg::PH_STROBE: r.enable_line = 1'b1;
      default: ;
    endcase
    r.ready_res = lcd_phase == lcdseq_pkg::PH_IDLE;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void compare_lines(lcdseq_pkg::result_t got);
    lcdseq_pkg::result_t want;
    if (expected_lines.size() == 0) begin
      errors++;
      $display("%0t mismatch: expected no transaction, actual %p", $time, got);
      return;
    end
    want = expected_lines.pop_front();
    check_field("reg_select", 8'(want.reg_select), 8'(got.reg_select));
    check_field("read_write", 8'(want.read_write), 8'(got.read_write));
    check_field("enable_line", 8'(want.enable_line), 8'(got.enable_line));
    check_field("bus_out", want.bus_out, got.bus_out);
    check_field("bus_drive", 8'(want.bus_drive), 8'(got.bus_drive));
    check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
    check_field("accepted", 8'(want.accepted), 8'(got.accepted));
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    lcdseq_pkg::item_t it;
    lcdseq_pkg::result_t got;
    if (rst) begin
      lcd_phase = lcdseq_pkg::PH_IDLE;
      tick_cnt = 16'd0;
      held_byte = 8'd0;
      held_rs = 1'b0;
      init_step = 3'd0;
      busy_flag = 1'b1;
      pulse_len = lcdseq_pkg::PULSE_TICKS_RESET;
      startup_len = lcdseq_pkg::STARTUP_TICKS_RESET;
      expected_lines.delete();
      item_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      item_taken <= push && !full;
      if (cfg_write) begin
        if (cfg_index == lcdseq_pkg::CFG_PULSE_TICKS) pulse_len = cfg_data[7:0];
        else startup_len = cfg_data;
      end
      if (push && !full) begin
        it.action = lcdseq_pkg::action_t'(action);
        it.byte_value = byte_value;
        it.busy_pin = busy_pin;
        expected_lines.push_back(predict_bus_lines(it));
      end
      if (pop && !empty) begin
        got.reg_select = reg_select;
        got.read_write = read_write;
        got.enable_line = enable_line;
        got.bus_out = bus_out;
        got.bus_drive = bus_drive;
        got.ready_res = ready_res;
        got.accepted = accepted;
        compare_lines(got);
      end
      if ((push && !full) || (pop && !empty) || cfg_write) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    logic go;
    if (item_taken) void'(pending_items.pop_front());
    if (push && !item_taken) go = pending_items.size() != 0;
    else go = pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
    push <= go;
    if (go) begin
      action <= pending_items[0].action;
      byte_value <= pending_items[0].byte_value;
      busy_pin <= pending_items[0].busy_pin;
    end
  end

  // result side
  always @(negedge clk) begin
    if (hold_off_done != hold_off_asked) begin
      hold_off_done <= hold_off_asked;
      stall_left <= LONG_HOLD;
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic add_item(lcdseq_pkg::action_t a, logic [7:0] b, logic p);
    lcdseq_pkg::item_t it;
    it.action = a;
    it.byte_value = b;
    it.busy_pin = p;
    pending_items.push_back(it);
  endtask

  task automatic add_ticks(int unsigned n, int unsigned busy_pct);
    repeat (n)
      add_item(lcdseq_pkg::ACT_TICK, 8'($urandom_range(255)), $urandom_range(99) < busy_pct);
  endtask

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || push || expected_lines.size() != 0);
  endtask

  task automatic run_until_idle();
    settle();
    while (lcd_phase != lcdseq_pkg::PH_IDLE) begin
      add_ticks(RUN_CHUNK, 25);
      settle();
    end
  endtask

  task automatic write_reg(lcdseq_pkg::cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == lcdseq_pkg::CFG_PULSE_TICKS) cur_pulse = 32'(val[7:0]);
    else cur_startup = 32'(val);
    @(posedge clk);
    #1;
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned added;
    int unsigned span;
    int unsigned p;
    int unsigned pick;
    added = 0;
    while (added < budget) begin
      p = (cur_pulse == 0) ? 1 : cur_pulse;
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: anything at any time
        add_item(lcdseq_pkg::action_t'($urandom_range(3)), 8'($urandom_range(255)),
                 1'($urandom_range(1)));
      end else begin
        if (pick < 18) begin
          add_item(lcdseq_pkg::ACT_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)));
          span = cur_startup + 20 * p;
        end else begin
          add_item(pick < 60 ? lcdseq_pkg::ACT_CMD : lcdseq_pkg::ACT_CHAR,
                   8'($urandom_range(255)), 1'($urandom_range(1)));
          span = 6 * p;
        end
        span = $urandom_range(span + 4, span / 2);
        repeat (span) begin
          if ($urandom_range(99) < 4)
            add_item(lcdseq_pkg::action_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
          add_item(lcdseq_pkg::ACT_TICK, 8'($urandom_range(255)), $urandom_range(99) < 25);
        end
        added += span + 1;
      end
    end
    run_until_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // directed, reset settings
    add_item(lcdseq_pkg::ACT_TICK, 8'h00, 1'b1);
    add_item(lcdseq_pkg::ACT_CMD, 8'h00, 1'b0);
    add_item(lcdseq_pkg::ACT_CHAR, 8'hFF, 1'b1);
    add_item(lcdseq_pkg::ACT_INIT, 8'h00, 1'b0);
    add_item(lcdseq_pkg::ACT_CMD, 8'h5A, 1'b0);
    run_until_idle();
    add_item(lcdseq_pkg::ACT_CHAR, 8'hFF, 1'b1);
    run_until_idle();
    add_item(lcdseq_pkg::ACT_CMD, 8'h80, 1'b0);
    add_ticks(10, 100);
    run_until_idle();
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS, 16'd1);
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'd3);
    add_item(lcdseq_pkg::ACT_INIT, 8'hC3, 1'b1);
    add_item(lcdseq_pkg::ACT_CMD, 8'h7F, 1'b0);
    add_ticks(4, 0);
    run_until_idle();
    add_item(lcdseq_pkg::ACT_TICK, 8'hFF, 1'b0);
    settle();

    // no idling, long result hold-off at the start
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'd5);
    hold_off_asked++;
    random_traffic(110);

    send_idle_pct = 63;
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS, 16'd2);
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'd1);
    random_traffic(110);

    send_idle_pct = 0;
    recv_stall_pct = 63;
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS, 16'd3);
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'd12);
    random_traffic(110);

    // zero intervals count as one tick
    send_idle_pct = 16;
    recv_stall_pct = 16;
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS, 16'd0);
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'd0);
    random_traffic(80);

    // largest settings, shortened once the long intervals have been entered
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS, 16'd255);
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'hFFFF);
    add_item(lcdseq_pkg::ACT_INIT, 8'h00, 1'b0);
    add_ticks(20, 0);
    settle();
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'd2);
    add_ticks(300, 0);
    settle();
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS, 16'd3);
    run_until_idle();

    send_idle_pct = 16;
    recv_stall_pct = 16;
    write_reg(lcdseq_pkg::CFG_PULSE_TICKS,
              {8'($urandom_range(255)), 8'($urandom_range(5, 1))});
    write_reg(lcdseq_pkg::CFG_STARTUP_TICKS, 16'($urandom_range(30, 1)));
    random_traffic(60);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lcdseq_pkg.sv
design/lcdseq_front.sv
design/lcdseq_back.sv
design/char_lcd_bus_sequencer_core.sv
tb/sv/char_lcd_bus_sequencer_core_tb.sv
